>>> hw/rtl/wfbp_pkg.sv
// Shared types, sizes and codes for the worst-fit bin packer.
package wfbp_pkg;

    localparam int MAX_BINS    = 64;
    localparam int IDX_W       = $clog2(MAX_BINS);
    localparam int CNT_W       = $clog2(MAX_BINS + 1);
    localparam int ROOM_W      = 17;
    localparam int BIN_INDEX_W = 6;
    localparam int BINS_USED_W = 7;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] STATUS_PLACED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_HEAVY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // control from the sequencer to the max-room unit
    typedef struct packed
    {
        logic             clear;
        logic             valid;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    // running best bin held by the max-room unit
    typedef struct packed
    {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [ROOM_W-1:0] room;
    } scan_best_t;

endpackage

>>> hw/rtl/wfbp_room_mem.sv
// Room-left memory: one write port, one registered read port.
module wfbp_room_mem
    import wfbp_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [ROOM_W-1:0] wdata,
    input  logic [IDX_W-1:0]  raddr,
    output logic [ROOM_W-1:0] rdata
);

    logic [ROOM_W-1:0] mem [MAX_BINS];
    logic [ROOM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/wfbp_max_unit.sv
// Shared compare unit: keeps the bin with the most room seen so far.
module wfbp_max_unit
    import wfbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  scan_ctl_t         ctl,
    input  logic [ROOM_W-1:0] room,
    output scan_best_t        best
);

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ROOM_W-1:0] room_reg, room_next;
    logic              take;

    // strict greater keeps the lowest index on a tie
    assign take = ctl.valid && (!found_reg || (room > room_reg));

    always_comb
    begin
        found_next = found_reg;
        idx_next   = idx_reg;
        room_next  = room_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
            idx_next   = ctl.idx;
            room_next  = room;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        room_reg <= room_next;
    end

    assign best.found = found_reg;
    assign best.idx   = idx_reg;
    assign best.room  = room_reg;

endmodule

>>> hw/rtl/worst_fit_bin_packer.sv
// Worst-fit bin packer top level: sequencer, bin count and result register.
// Each request carries one weight; the block scans every open bin through the single read
// port of the room memory, one bin per cycle, to find the bin with the most room, then
// writes back the updated room. After the last bin it passes through the drain, decide
// and output states before the next accept; with no bin open it skips the scan and drain,
// and an overweight item goes from accept straight to the output state. The result turns
// valid in the cycle in which the next item can be accepted. s_tready is low while an item
// is being worked; one finished result may wait in the output register while the next item
// is accepted. bin_capacity is written on the cfg channel, which is always ready.
module worst_fit_bin_packer
    import wfbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data,      // bin_capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [16:0] item_weight, [23:17] zero
    input  logic [0:0]  s_tuser,       // [0] start_new
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [5:0] bin_index, [6] opened_bin,
                                       // [13:7] bins_used, [15:14] status
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  open_count_reg, open_count_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [ROOM_W-1:0] weight_reg, weight_next;
    logic [ROOM_W-1:0] cap_reg;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              res_opened_reg, res_opened_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;

    logic              accept;
    logic [ROOM_W-1:0] in_weight;
    logic [CNT_W-1:0]  count_now;
    logic              too_heavy;
    logic              last_scan;
    logic              fit;
    logic              has_space;
    logic              out_free;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [ROOM_W-1:0] mem_wdata;
    logic [ROOM_W-1:0] mem_rdata;
    scan_ctl_t         ctl;
    scan_best_t        best;

    assign in_weight = s_tdata[ROOM_W-1:0];
    assign accept    = s_tvalid && s_tready;
    assign count_now = s_tuser[0] ? '0 : open_count_reg;
    assign too_heavy = in_weight > cap_reg;
    assign last_scan = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == open_count_reg;
    assign fit       = best.found && (best.room >= weight_reg);
    assign has_space = open_count_reg < CNT_W'(MAX_BINS);
    assign out_free  = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (too_heavy)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (count_now == '0)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last_scan)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        open_count_next = open_count_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = scan_idx_reg;
        weight_next     = weight_reg;
        res_idx_next    = res_idx_reg;
        res_opened_next = res_opened_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = best.idx;
        mem_wdata       = best.room - weight_reg;
        ctl.clear       = 1'b0;
        ctl.valid       = pend_valid_reg;
        ctl.idx         = pend_idx_reg;
        s_tready        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    open_count_next = count_now;
                    weight_next     = in_weight;
                    scan_idx_next   = '0;
                    ctl.clear       = 1'b1;
                    res_idx_next    = '0;
                    res_opened_next = 1'b0;
                    res_status_next = STATUS_TOO_HEAVY;
                end
            end
            ST_SCAN:
            begin
                pend_valid_next = 1'b1;
                scan_idx_next   = scan_idx_reg + IDX_W'(1);
            end
            ST_DECIDE:
            begin
                if (fit)
                begin
                    mem_we          = 1'b1;
                    res_idx_next    = best.idx;
                    res_opened_next = 1'b0;
                    res_status_next = STATUS_PLACED;
                end
                else if (has_space)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = open_count_reg[IDX_W-1:0];
                    mem_wdata       = cap_reg - weight_reg;
                    open_count_next = open_count_reg + CNT_W'(1);
                    res_idx_next    = open_count_reg[IDX_W-1:0];
                    res_opened_next = 1'b1;
                    res_status_next = STATUS_PLACED;
                end
                else
                begin
                    res_idx_next    = '0;
                    res_opened_next = 1'b0;
                    res_status_next = STATUS_FULL;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_status_reg,
                                     BINS_USED_W'(open_count_reg),
                                     res_opened_reg,
                                     BIN_INDEX_W'(res_idx_reg)};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            open_count_reg <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            cap_reg        <= 17'h10000;
        end
        else
        begin
            state_reg      <= state_next;
            open_count_reg <= open_count_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        weight_reg     <= weight_next;
        res_idx_reg    <= res_idx_next;
        res_opened_reg <= res_opened_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    wfbp_room_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (scan_idx_reg),
        .rdata (mem_rdata)
    );

    wfbp_max_unit u_max
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .room  (mem_rdata),
        .best  (best)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_count_reg <= CNT_W'(MAX_BINS))
        else $error("open bin count above table size");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) && best.found |-> CNT_W'(best.idx) < open_count_reg)
        else $error("best bin beyond open bins");

    a_new_bin_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6] |->
        (m_tdata[13:7] == BINS_USED_W'(m_tdata[5:0]) + BINS_USED_W'(1)))
        else $error("opened bin is not the last bin");

    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[15:14] != STATUS_PLACED) |-> !m_tdata[6] && m_tdata[5:0] == '0)
        else $error("refused item reports a bin");

endmodule
